[rtl/oopc_pkg.sv]
// ----------------------------------------------------------------------------
// oopc_pkg
// Shared types, constants and helpers of the order-preserving compactor.
// ----------------------------------------------------------------------------
`default_nettype none

package oopc_pkg;

   localparam int MAX_ITEMS_DEF    = 64;
   localparam int PAYLOAD_BITS_DEF = 64;
   localparam int PTR_W            = 7;   // holds any index or count up to 64
   localparam int TOTAL_W          = 7;
   localparam int DATA_W           = 64;
   localparam int RSP_DATA_W       = 72;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_ENTER,
      ST_EVAL,
      ST_LEAF_EVAL,
      ST_RETURN,
      ST_LOOP,
      ST_SW_RD,
      ST_SW_WA,
      ST_SW_WB,
      ST_EM_RD,
      ST_EM_LD,
      ST_EM_WAIT
   } state_type;

   typedef enum logic {
      KIND_ANY,
      KIND_POW
   } kind_type;

   typedef struct packed {
      logic             load_we;
      logic [PTR_W-1:0] load_idx;
      logic             mem_rd;
      logic [PTR_W-1:0] rd_a;
      logic [PTR_W-1:0] rd_b;
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic             wr_from_b;
      logic             pfx_rd;
      logic [PTR_W-1:0] pfx_a;
      logic [PTR_W-1:0] pfx_b;
      logic             out_load;
      logic             out_last;
      logic             total_clr;
   } dp_cmd_type;

   typedef struct packed {
      kind_type         kind;
      logic [1:0]       phase;
      logic [PTR_W-1:0] base;
      logic [PTR_W-1:0] n;
      logic [PTR_W-1:0] off;
      logic [PTR_W-1:0] m;
   } frame_type;

   function automatic logic [PTR_W-1:0] hi_pow2(input logic [PTR_W-1:0] n);
      logic [PTR_W-1:0] p;
      logic             found;
      p     = '0;
      found = 1'b0;
      for (int k = PTR_W - 1; k >= 0; k--) begin
         if (!found && n[k]) begin
            p[k]  = 1'b1;
            found = 1'b1;
         end
      end
      return p;
   endfunction

endpackage

`default_nettype wire

[rtl/oopc_ctrl.sv]
// ----------------------------------------------------------------------------
// oopc_ctrl
// Sequencer: loads the run, walks the compaction recursion on a frame stack,
// issues swap and emit commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module oopc_ctrl #(
   parameter int MAX_ITEMS = oopc_pkg::MAX_ITEMS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   input  wire                           req_tlast,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   output oopc_pkg::dp_cmd_type          cmd,
   input  wire  [oopc_pkg::PTR_W-1:0]    pfx_diff
);

   localparam int P         = oopc_pkg::PTR_W;
   localparam int IDX_W     = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
   localparam int STK_DEPTH = 2 * IDX_W + 2;
   localparam int STK_IDX_W = $clog2(STK_DEPTH);
   localparam int SP_W      = $clog2(STK_DEPTH + 1);

   oopc_pkg::state_type state_ff, state_in;
   logic [P-1:0]        cnt_ff, cnt_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   oopc_pkg::frame_type stack_ff [STK_DEPTH];
   logic [P-1:0]        i_ff, i_in;
   logic [P-1:0]        j_ff, j_in;
   logic                flag_ff, flag_in;
   logic                leaf_ff, leaf_in;
   logic [P-1:0]        sw_a_ff, sw_a_in;
   logic [P-1:0]        sw_b_ff, sw_b_in;

   logic                push, pop, upd;
   oopc_pkg::frame_type push_frame, upd_frame, top;
   logic [SP_W-1:0]     sp_dec;
   logic [STK_IDX_W-1:0] top_idx, push_idx;

   logic [P-1:0] p, s, h, hmask, om, om1, po, split, loop_len, far, addr_a, addr_b;
   logic         flag0, cond, is_pow, leaf_cond;

   assign sp_dec   = sp_ff - 1'b1;
   assign top_idx  = sp_dec[STK_IDX_W-1:0];
   assign push_idx = sp_ff[STK_IDX_W-1:0];
   assign top      = stack_ff[top_idx];
   assign is_pow   = (top.kind == oopc_pkg::KIND_POW);

   assign p        = oopc_pkg::hi_pow2(top.n);
   assign s        = top.n - p;
   assign h        = top.n >> 1;
   assign hmask    = h - 1'b1;
   assign om       = top.off & hmask;
   assign om1      = (top.off + top.m) & hmask;
   assign flag0    = ((om + top.m) >= h) ^ (top.off >= h);
   assign po       = (p - s + top.m) & (p - 1'b1);
   assign split    = (top.n == P'(2)) ? P'(1) : (is_pow ? h : s);
   assign loop_len = is_pow ? h : s;
   assign far      = is_pow ? h : p;
   assign addr_a   = top.base + i_ff;
   assign addr_b   = top.base + far + i_ff;
   assign cond     = is_pow ? (flag_ff ^ (i_ff == om1)) : (i_ff >= top.m);
   assign leaf_cond = (~top.m[0] & pfx_diff[0]) ^ (is_pow & top.off[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oopc_pkg::ST_LOAD;
         cnt_ff   <= '0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sp_ff    <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      flag_ff <= flag_in;
      leaf_ff <= leaf_in;
      sw_a_ff <= sw_a_in;
      sw_b_ff <= sw_b_in;
      if (upd) begin
         stack_ff[top_idx] <= upd_frame;
      end
      if (push) begin
         stack_ff[push_idx] <= push_frame;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      flag_in    = flag_ff;
      leaf_in    = leaf_ff;
      sw_a_in    = sw_a_ff;
      sw_b_in    = sw_b_ff;
      push       = 1'b0;
      pop        = 1'b0;
      upd        = 1'b0;
      push_frame = top;
      upd_frame  = top;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      case (state_ff)
         oopc_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_we  = 1'b1;
               cmd.load_idx = cnt_ff;
               cnt_in       = cnt_ff + 1'b1;
               if (req_tlast || cnt_ff == P'(MAX_ITEMS - 1)) begin
                  push       = 1'b1;
                  push_frame = '{kind: oopc_pkg::KIND_ANY, phase: 2'd0, base: '0,
                                 n: cnt_ff + 1'b1, off: '0, m: '0};
                  state_in   = oopc_pkg::ST_ENTER;
               end
            end
         end
         oopc_pkg::ST_ENTER: begin
            if (top.n < P'(2)) begin
               pop      = 1'b1;
               state_in = oopc_pkg::ST_RETURN;
            end else begin
               cmd.pfx_rd = 1'b1;
               cmd.pfx_a  = top.base + split;
               cmd.pfx_b  = top.base;
               state_in   = oopc_pkg::ST_EVAL;
            end
         end
         oopc_pkg::ST_EVAL: begin
            upd         = 1'b1;
            upd_frame.m = pfx_diff;
            if (top.n == P'(2)) begin
               cmd.pfx_rd = 1'b1;
               cmd.pfx_a  = top.base + P'(2);
               cmd.pfx_b  = top.base + P'(1);
               state_in   = oopc_pkg::ST_LEAF_EVAL;
            end else begin
               upd_frame.phase = 2'd1;
               push            = 1'b1;
               if (is_pow) begin
                  push_frame = '{kind: oopc_pkg::KIND_POW, phase: 2'd0, base: top.base,
                                 n: h, off: om, m: '0};
               end else begin
                  push_frame = '{kind: oopc_pkg::KIND_ANY, phase: 2'd0, base: top.base,
                                 n: s, off: '0, m: '0};
               end
               state_in = oopc_pkg::ST_ENTER;
            end
         end
         oopc_pkg::ST_LEAF_EVAL: begin
            if (leaf_cond) begin
               sw_a_in  = top.base;
               sw_b_in  = top.base + P'(1);
               leaf_in  = 1'b1;
               state_in = oopc_pkg::ST_SW_RD;
            end else begin
               pop      = 1'b1;
               state_in = oopc_pkg::ST_RETURN;
            end
         end
         oopc_pkg::ST_RETURN: begin
            if (sp_ff == '0) begin
               j_in     = '0;
               state_in = oopc_pkg::ST_EM_RD;
            end else if (top.phase == 2'd1) begin
               upd             = 1'b1;
               upd_frame.phase = 2'd2;
               push            = 1'b1;
               if (is_pow) begin
                  push_frame = '{kind: oopc_pkg::KIND_POW, phase: 2'd0,
                                 base: top.base + h, n: h, off: om1, m: '0};
               end else begin
                  push_frame = '{kind: oopc_pkg::KIND_POW, phase: 2'd0,
                                 base: top.base + s, n: p, off: po, m: '0};
               end
               state_in = oopc_pkg::ST_ENTER;
            end else begin
               i_in     = '0;
               flag_in  = flag0;
               state_in = oopc_pkg::ST_LOOP;
            end
         end
         oopc_pkg::ST_LOOP: begin
            if (i_ff >= loop_len) begin
               pop      = 1'b1;
               state_in = oopc_pkg::ST_RETURN;
            end else if (cond) begin
               sw_a_in  = addr_a;
               sw_b_in  = addr_b;
               leaf_in  = 1'b0;
               state_in = oopc_pkg::ST_SW_RD;
            end else begin
               flag_in = cond;
               i_in    = i_ff + 1'b1;
            end
         end
         oopc_pkg::ST_SW_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_a   = sw_a_ff;
            cmd.rd_b   = sw_b_ff;
            state_in   = oopc_pkg::ST_SW_WA;
         end
         oopc_pkg::ST_SW_WA: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_addr   = sw_a_ff;
            cmd.wr_from_b = 1'b1;
            state_in      = oopc_pkg::ST_SW_WB;
         end
         oopc_pkg::ST_SW_WB: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = sw_b_ff;
            if (leaf_ff) begin
               pop      = 1'b1;
               state_in = oopc_pkg::ST_RETURN;
            end else begin
               flag_in  = cond;
               i_in     = i_ff + 1'b1;
               state_in = oopc_pkg::ST_LOOP;
            end
         end
         oopc_pkg::ST_EM_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_a   = j_ff;
            cmd.rd_b   = j_ff;
            state_in   = oopc_pkg::ST_EM_LD;
         end
         oopc_pkg::ST_EM_LD: begin
            cmd.out_load = 1'b1;
            cmd.out_last = (j_ff + 1'b1 == cnt_ff);
            state_in     = oopc_pkg::ST_EM_WAIT;
         end
         oopc_pkg::ST_EM_WAIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (j_ff + 1'b1 == cnt_ff) begin
                  cnt_in        = '0;
                  cmd.total_clr = 1'b1;
                  state_in      = oopc_pkg::ST_LOAD;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = oopc_pkg::ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = oopc_pkg::ST_LOAD;
         end
      endcase

      sp_in = sp_ff + SP_W'(push) - SP_W'(pop);
   end

endmodule

`default_nettype wire

[rtl/oopc_dp.sv]
// ----------------------------------------------------------------------------
// oopc_dp
// Datapath: element memory with swap port, prefix count memory, selected
// total and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oopc_dp #(
   parameter int MAX_ITEMS    = oopc_pkg::MAX_ITEMS_DEF,
   parameter int PAYLOAD_BITS = oopc_pkg::PAYLOAD_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  oopc_pkg::dp_cmd_type               cmd,
   input  wire  [oopc_pkg::DATA_W-1:0]        req_tdata,
   input  wire                                req_tuser,
   output logic [oopc_pkg::PTR_W-1:0]         pfx_diff,
   output logic [oopc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int P     = oopc_pkg::PTR_W;
   localparam int IDX_W = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
   localparam int W     = PAYLOAD_BITS + 1;

   logic [W-1:0] word_mem [MAX_ITEMS];
   logic [P-1:0] pfx_mem  [MAX_ITEMS];

   logic [W-1:0] rd_a_ff, rd_b_ff, out_ff;
   logic         out_last_ff;
   logic [P-1:0] pa_ff, pb_ff, total_ff, total_in;
   logic         pa_zero_ff, pb_zero_ff;
   logic [P-1:0] pa_addr, pb_addr;

   assign pa_addr = cmd.pfx_a - 1'b1;
   assign pb_addr = cmd.pfx_b - 1'b1;
   assign total_in = total_ff + P'(req_tuser);

   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         word_mem[cmd.load_idx[IDX_W-1:0]] <= {req_tuser, req_tdata[PAYLOAD_BITS-1:0]};
         pfx_mem[cmd.load_idx[IDX_W-1:0]]  <= total_in;
      end else if (cmd.wr_en) begin
         word_mem[cmd.wr_addr[IDX_W-1:0]] <= cmd.wr_from_b ? rd_b_ff : rd_a_ff;
      end
      if (cmd.mem_rd) begin
         rd_a_ff <= word_mem[cmd.rd_a[IDX_W-1:0]];
         rd_b_ff <= word_mem[cmd.rd_b[IDX_W-1:0]];
      end
      if (cmd.pfx_rd) begin
         pa_ff      <= pfx_mem[pa_addr[IDX_W-1:0]];
         pb_ff      <= pfx_mem[pb_addr[IDX_W-1:0]];
         pa_zero_ff <= (cmd.pfx_a == '0);
         pb_zero_ff <= (cmd.pfx_b == '0);
      end
      if (cmd.out_load) begin
         out_ff      <= rd_a_ff;
         out_last_ff <= cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cmd.total_clr) begin
         total_ff <= '0;
      end else if (cmd.load_we) begin
         total_ff <= total_in;
      end
   end

   assign pfx_diff  = (pa_zero_ff ? P'(0) : pa_ff) - (pb_zero_ff ? P'(0) : pb_ff);
   assign rsp_tdata = {1'b0, oopc_pkg::TOTAL_W'(total_ff),
                       oopc_pkg::DATA_W'(out_ff[PAYLOAD_BITS-1:0])};
   assign rsp_tuser = out_ff[PAYLOAD_BITS];
   assign rsp_tlast = out_last_ff;

endmodule

`default_nettype wire

[rtl/oblivious_order_preserving_compactor.sv]
// Load: one item per cycle; the item with tlast (or the MAX_ITEMS-th) closes the run.
// Compaction of n items: the swap network runs one conditional swap at a time
//   through the single write port of the element memory.
// Emit: each result takes a memory read, a result register load and the transfer.
// Reset: synchronous; returns to loading an empty run, stores keep stale contents.
// ----------------------------------------------------------------------------
// oblivious_order_preserving_compactor
// Order-preserving oblivious compaction of a run of payload words.
// ----------------------------------------------------------------------------
`default_nettype none

module oblivious_order_preserving_compactor #(
   parameter int MAX_ITEMS    = oopc_pkg::MAX_ITEMS_DEF,
   parameter int PAYLOAD_BITS = oopc_pkg::PAYLOAD_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [oopc_pkg::DATA_W-1:0]        req_tdata,   // [63:0] payload
   input  wire                                req_tuser,   // [0] keep_flag
   input  wire                                req_tlast,   // final_item
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [oopc_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [63:0] out_payload,
                                                           // [70:64] selected_total
   output logic                               rsp_tuser,   // [0] out_keep_flag
   output logic                               rsp_tlast    // final_result
);

   oopc_pkg::dp_cmd_type       cmd;
   logic [oopc_pkg::PTR_W-1:0] pfx_diff;

   oopc_ctrl #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .pfx_diff   (pfx_diff)
   );

   oopc_dp #(
      .MAX_ITEMS    (MAX_ITEMS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .pfx_diff  (pfx_diff),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

`default_nettype wire

[rtl/oopc_chk.sv]
// ----------------------------------------------------------------------------
// oopc_chk
// Port-level checks of the compactor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module oopc_chk (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire                             req_tlast,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [oopc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire                             rsp_tuser,
   input wire                             rsp_tlast
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result channels active together");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                     && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result transfer changed");

   a_close_run: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready && !rsp_tvalid)
      else $error("run close did not start compaction");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not loading after reset");

   a_run_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("no return to loading after last result");

endmodule

bind oblivious_order_preserving_compactor oopc_chk u_chk (.*);

`default_nettype wire
